>>> hw/rtl/double_hash_table_insert_delete_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-hash table core
// Shared concurrent check forms, clocked and masked while reset is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_TABLE_INSERT_DELETE_CORE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_INSERT_DELETE_CORE_DEFINES_SVH

// Same-cycle implication
`define DHTID_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dhtid: same-cycle check failed");

// Next-cycle implication
`define DHTID_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dhtid: next-cycle check failed");

`endif

>>> hw/rtl/dhtid_pkg.sv
// ----------------------------------------------------------------------------
// dhtid_pkg
// Field widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package dhtid_pkg;

    localparam int FUNC_W   = 1;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;
    localparam int SLOT_W   = 4;
    localparam int MARK_W   = 2;

    // key reduced MSB first, one digit per cycle
    localparam int HASH_DIGIT  = 8;
    localparam int HASH_CYCLES = 4;
    localparam int HASH_CNT_W  = 2;
    localparam int KEY_PAD     = HASH_DIGIT * HASH_CYCLES;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 1'b1;

    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    localparam logic [STATUS_W-1:0] RES_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] RES_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] RES_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] RES_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic load;     // take a new item
        logic hash;     // one digit of key reduction
        logic prep;     // set up the probe walk
        logic probe;    // issue one read, evaluate the previous one
        logic commit;   // write the table and load the result register
    } dhtid_cmd_t;

    typedef struct packed {
        logic hash_done;
        logic walk_done;
    } dhtid_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/dhtid_ram.sv
// ----------------------------------------------------------------------------
// dhtid_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dhtid_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 11
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dhtid_dp.sv
// ----------------------------------------------------------------------------
// dhtid_dp
// Datapath: key reduction, probe address walk, slot evaluation, table store.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_hash_table_insert_delete_core_defines.svh"

module dhtid_dp #(
    parameter int TABLE_SIZE = 11,
    parameter int STEP_PRIME = 3
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire dhtid_pkg::dhtid_cmd_t           cmd,
    output dhtid_pkg::dhtid_sts_t                sts,
    input  wire logic [dhtid_pkg::FUNC_W-1:0]    s_func,
    input  wire logic [dhtid_pkg::KEY_W-1:0]     s_key,
    output logic      [dhtid_pkg::STATUS_W-1:0]  m_status,
    output logic      [dhtid_pkg::COUNT_W-1:0]   m_count,
    output logic      [dhtid_pkg::SLOT_W-1:0]    m_slot
);

    import dhtid_pkg::*;

    localparam int SW = $clog2(TABLE_SIZE);
    localparam int PW = $clog2(STEP_PRIME);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam int EW = MARK_W + KEY_W;

    localparam logic [SW:0]   N_W    = (SW+1)'(TABLE_SIZE);
    localparam logic [PW:0]   P_W    = (PW+1)'(STEP_PRIME);
    localparam logic [CW-1:0] N_CNT  = CW'(TABLE_SIZE);
    localparam logic [CW-1:0] N_LAST = CW'(TABLE_SIZE - 1);

    // item and hashing
    logic [FUNC_W-1:0]     func_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_PAD-1:0]    shift_reg, shift_next;
    logic [HASH_CNT_W-1:0] hash_cnt_reg, hash_cnt_next;
    logic [SW-1:0]         rn_reg, rn_next;
    logic [PW-1:0]         rp_reg, rp_next;
    logic [SW:0]           tn;
    logic [PW:0]           tp;

    // probe walk
    logic [SW-1:0] addr_reg, addr_next;
    logic [SW-1:0] step_reg;
    logic [SW:0]   step_full, step_mod, addr_sum;
    logic [CW-1:0] iss_cnt_reg, iss_cnt_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [SW-1:0] rd_slot_reg, rd_slot_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;

    // evaluation
    logic [CW-1:0]       clash_reg, clash_next, clash_cur;
    logic                tomb_vld_reg, tomb_vld_next, tomb_vld_cur;
    logic [SW-1:0]       tomb_slot_reg, tomb_slot_next, tomb_slot_cur;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [CW-1:0]       res_count_reg, res_count_next;
    logic [SW-1:0]       res_slot_reg, res_slot_next;
    logic                res_we_reg, res_we_next;
    logic [MARK_W-1:0]   res_mark_reg, res_mark_next;

    // table store
    logic [TABLE_SIZE-1:0] vld_reg, vld_next;
    logic [EW-1:0]         rd_data;
    logic [MARK_W-1:0]     mark;
    logic                  hit;
    logic                  last;
    logic                  eval;

    // result register
    logic [STATUS_W-1:0] m_status_reg;
    logic [COUNT_W-1:0]  m_count_reg;
    logic [SLOT_W-1:0]   m_slot_reg;

    dhtid_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (cmd.commit && res_we_reg),
        .wr_addr (res_slot_reg),
        .wr_data ({res_mark_reg, key_reg}),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // one digit of both residues, MSB first
    always_comb begin
        rn_next       = rn_reg;
        rp_next       = rp_reg;
        shift_next    = shift_reg;
        hash_cnt_next = hash_cnt_reg;
        tn            = '0;
        tp            = '0;
        if (cmd.load) begin
            rn_next       = '0;
            rp_next       = '0;
            shift_next    = KEY_PAD'(s_key);
            hash_cnt_next = '0;
        end else if (cmd.hash) begin
            for (int j = 0; j < HASH_DIGIT; j++) begin
                tn = {rn_next, shift_reg[KEY_PAD-1-j]};
                if (tn >= N_W) begin
                    tn = tn - N_W;
                end
                rn_next = tn[SW-1:0];
                tp = {rp_next, shift_reg[KEY_PAD-1-j]};
                if (tp >= P_W) begin
                    tp = tp - P_W;
                end
                rp_next = tp[PW-1:0];
            end
            shift_next    = shift_reg << HASH_DIGIT;
            hash_cnt_next = hash_cnt_reg + HASH_CNT_W'(1);
        end
    end

    // step reduced below the table size so one subtract wraps the address
    always_comb begin
        step_full = (SW+1)'(rp_reg) + (SW+1)'(1);
        step_mod  = (step_full >= N_W) ? step_full - N_W : step_full;
        addr_sum  = {1'b0, addr_reg} + {1'b0, step_reg};
        if (addr_sum >= N_W) begin
            addr_sum = addr_sum - N_W;
        end
    end

    always_comb begin
        addr_next    = addr_reg;
        iss_cnt_next = iss_cnt_reg;
        rd_vld_next  = rd_vld_reg;
        rd_slot_next = rd_slot_reg;
        rd_idx_next  = rd_idx_reg;
        if (cmd.prep) begin
            addr_next    = rn_reg;
            iss_cnt_next = '0;
            rd_vld_next  = 1'b0;
        end else if (cmd.probe) begin
            if (iss_cnt_reg < N_CNT) begin
                rd_vld_next  = 1'b1;
                rd_slot_next = addr_reg;
                rd_idx_next  = iss_cnt_reg;
                addr_next    = addr_sum[SW-1:0];
                iss_cnt_next = iss_cnt_reg + CW'(1);
            end else begin
                rd_vld_next = 1'b0;
            end
        end
    end

    assign mark = vld_reg[rd_slot_reg] ? rd_data[KEY_W +: MARK_W] : MARK_EMPTY;
    assign hit  = (mark == MARK_USED) && (rd_data[KEY_W-1:0] == key_reg);
    assign last = (rd_idx_reg == N_LAST);
    assign eval = cmd.probe && rd_vld_reg && !done_reg;

    always_comb begin
        clash_cur     = (mark == MARK_USED) ? clash_reg + CW'(1) : clash_reg;
        tomb_vld_cur  = tomb_vld_reg;
        tomb_slot_cur = tomb_slot_reg;
        if ((mark != MARK_EMPTY) && (mark != MARK_USED) && !tomb_vld_reg) begin
            tomb_vld_cur  = 1'b1;
            tomb_slot_cur = rd_slot_reg;
        end
    end

    always_comb begin
        clash_next      = clash_reg;
        tomb_vld_next   = tomb_vld_reg;
        tomb_slot_next  = tomb_slot_reg;
        done_next       = done_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        res_slot_next   = res_slot_reg;
        res_we_next     = res_we_reg;
        res_mark_next   = res_mark_reg;
        if (cmd.prep) begin
            clash_next    = '0;
            tomb_vld_next = 1'b0;
            done_next     = 1'b0;
        end else if (eval) begin
            if (func_reg == FUNC_INSERT) begin
                priority if (mark == MARK_EMPTY) begin
                    done_next       = 1'b1;
                    res_status_next = RES_INSERTED;
                    res_count_next  = clash_reg;
                    res_slot_next   = tomb_vld_reg ? tomb_slot_reg : rd_slot_reg;
                    res_we_next     = 1'b1;
                    res_mark_next   = MARK_USED;
                end else if (hit) begin
                    done_next       = 1'b1;
                    res_status_next = RES_DUPLICATE;
                    res_count_next  = '0;
                    res_slot_next   = '0;
                    res_we_next     = 1'b0;
                end else begin
                    clash_next     = clash_cur;
                    tomb_vld_next  = tomb_vld_cur;
                    tomb_slot_next = tomb_slot_cur;
                    if (last) begin
                        done_next      = 1'b1;
                        res_count_next = clash_cur;
                        res_mark_next  = MARK_USED;
                        if (tomb_vld_cur) begin
                            res_status_next = RES_INSERTED;
                            res_slot_next   = tomb_slot_cur;
                            res_we_next     = 1'b1;
                        end else begin
                            res_status_next = RES_FULL;
                            res_slot_next   = '0;
                            res_we_next     = 1'b0;
                        end
                    end
                end
            end else begin
                priority if (hit) begin
                    done_next       = 1'b1;
                    res_status_next = RES_DELETED;
                    res_count_next  = rd_idx_reg + CW'(1);
                    res_slot_next   = rd_slot_reg;
                    res_we_next     = 1'b1;
                    res_mark_next   = MARK_DELETED;
                end else if (last) begin
                    done_next       = 1'b1;
                    res_status_next = RES_NOT_FOUND;
                    res_count_next  = '0;
                    res_slot_next   = '0;
                    res_we_next     = 1'b0;
                end else begin
                    done_next = 1'b0;
                end
            end
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (cmd.commit && res_we_reg) begin
            vld_next[res_slot_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            done_reg     <= 1'b0;
            rd_vld_reg   <= 1'b0;
            hash_cnt_reg <= '0;
            iss_cnt_reg  <= '0;
        end else begin
            vld_reg      <= vld_next;
            done_reg     <= done_next;
            rd_vld_reg   <= rd_vld_next;
            hash_cnt_reg <= hash_cnt_next;
            iss_cnt_reg  <= iss_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            key_reg  <= s_key;
        end
        if (cmd.prep) begin
            step_reg <= step_mod[SW-1:0];
        end
        if (cmd.commit) begin
            m_status_reg <= res_status_reg;
            m_count_reg  <= COUNT_W'(res_count_reg);
            m_slot_reg   <= SLOT_W'(res_slot_reg);
        end
        shift_reg      <= shift_next;
        rn_reg         <= rn_next;
        rp_reg         <= rp_next;
        addr_reg       <= addr_next;
        rd_slot_reg    <= rd_slot_next;
        rd_idx_reg     <= rd_idx_next;
        clash_reg      <= clash_next;
        tomb_vld_reg   <= tomb_vld_next;
        tomb_slot_reg  <= tomb_slot_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        res_slot_reg   <= res_slot_next;
        res_we_reg     <= res_we_next;
        res_mark_reg   <= res_mark_next;
    end

    assign sts.hash_done = (hash_cnt_reg == HASH_CNT_W'(HASH_CYCLES - 1));
    assign sts.walk_done = done_reg;

    assign m_status = m_status_reg;
    assign m_count  = m_count_reg;
    assign m_slot   = m_slot_reg;

    `DHTID_ASSERT_NOW(a_iss_bound, aclk, aresetn, 1'b1, iss_cnt_reg <= N_CNT)
    `DHTID_ASSERT_NOW(a_rd_idx_bound, aclk, aresetn, rd_vld_reg, rd_idx_reg < N_CNT)
    `DHTID_ASSERT_NEXT(a_eval_done, aclk, aresetn, eval && last, done_reg)

endmodule

`default_nettype wire

>>> hw/rtl/dhtid_ctrl.sv
// ----------------------------------------------------------------------------
// dhtid_ctrl
// Controller: sequences hash, probe walk and commit; owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_hash_table_insert_delete_core_defines.svh"

module dhtid_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output dhtid_pkg::dhtid_cmd_t      cmd,
    input  wire dhtid_pkg::dhtid_sts_t sts
);

    import dhtid_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_HASH   = 5'b00010,
        S_PREP   = 5'b00100,
        S_PROBE  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash = 1'b1;
                if (sts.hash_done) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE: begin
                cmd.probe = 1'b1;
                if (sts.walk_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the result register has room
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    `DHTID_ASSERT_NOW(a_commit_room, aclk, aresetn, cmd.commit, out_free)
    `DHTID_ASSERT_NEXT(a_commit_valid, aclk, aresetn, cmd.commit, m_valid_reg)
    `DHTID_ASSERT_NOW(a_prep_after_hash, aclk, aresetn, state_reg == S_PREP, $past(sts.hash_done))

endmodule

`default_nettype wire

>>> hw/rtl/double_hash_table_insert_delete_core.sv
// ----------------------------------------------------------------------------
// double_hash_table_insert_delete_core
// Open-addressing hash table with double hashing and deleted-slot reuse.
// ----------------------------------------------------------------------------
//  channel | direction | ports                              | handshake
//  --------+-----------+------------------------------------+----------------
//  s_      | in        | s_func, s_key                      | s_valid/s_ready
//  m_      | out       | m_status, m_count, m_slot          | m_valid/m_ready
//
//  One item at a time: accept, key reduction, probe setup, the probe walk
//  of P <= TABLE_SIZE probes and commit, in that order. The probe walk is
//  set by the single table RAM read port, one slot per cycle.
//  Reset clears the slot valid bits at once; no clearing pass is needed.
//  A result waiting in the output register does not block the next transfer in;
//  the commit of the following item holds until that result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module double_hash_table_insert_delete_core #(
    parameter int TABLE_SIZE = 11,
    parameter int STEP_PRIME = 3
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [dhtid_pkg::FUNC_W-1:0]    s_func,
    input  wire logic [dhtid_pkg::KEY_W-1:0]     s_key,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [dhtid_pkg::STATUS_W-1:0]  m_status,
    output logic      [dhtid_pkg::COUNT_W-1:0]   m_count,
    output logic      [dhtid_pkg::SLOT_W-1:0]    m_slot
);

    import dhtid_pkg::*;

    dhtid_cmd_t cmd;
    dhtid_sts_t sts;

    dhtid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    dhtid_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .STEP_PRIME (STEP_PRIME)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_func   (s_func),
        .s_key    (s_key),
        .m_status (m_status),
        .m_count  (m_count),
        .m_slot   (m_slot)
    );

endmodule

`default_nettype wire
